>>> rtl/force_peak_bar_meter_macros.svh
// assertion helpers for the force bar meter
`ifndef FORCE_PEAK_BAR_METER_MACROS_SVH
`define FORCE_PEAK_BAR_METER_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define FPBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define FPBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fpbm_pkg.sv
package fpbm_pkg;

    localparam int BAR_LEDS = 6;

    localparam int FORCE_W    = 23;
    localparam int SAMPLE_W   = 24;
    localparam int TIME_W     = 32;
    localparam int WEIGHT_W   = 9;
    localparam int THRESH_W   = 12;
    localparam int COUNT_W    = 4;
    localparam int INTERVAL_W = 16;
    localparam int FS_W       = 16;
    localparam int LED_W      = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int WEIGHT_ONE = 256;
    localparam int ROUND_HALF = 128;
    localparam int W_SHIFT    = 8;
    localparam int ACC_W      = FORCE_W + WEIGHT_W;
    localparam int STEADY_MAX = 15;

    localparam int BAR_SCALE_W = $clog2(2 * BAR_LEDS * ((2 ** FS_W) - 1) + 1);
    localparam int BAR_CNT_W   = $clog2(BAR_LEDS + 1);

    localparam logic [WEIGHT_W-1:0]   FILTER_WEIGHT_RST = 9'd205;
    localparam logic [THRESH_W-1:0]   STABLE_THRESH_RST = 12'd41;
    localparam logic [COUNT_W-1:0]    STABLE_COUNT_RST  = 4'd5;
    localparam logic [INTERVAL_W-1:0] STABLE_IVL_RST    = 16'd500;
    localparam logic [INTERVAL_W-1:0] UNSTABLE_IVL_RST  = 16'd250;
    localparam logic [THRESH_W-1:0]   DEADZONE_RST      = 12'd82;
    localparam logic [FS_W-1:0]       FULL_SCALE_RST    = 16'd40550;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_WEIGHT        = 3'd0,
        REG_STABLE_THRESHOLD     = 3'd1,
        REG_STABLE_COUNT_NEEDED  = 3'd2,
        REG_STABLE_INTERVAL_MS   = 3'd3,
        REG_UNSTABLE_INTERVAL_MS = 3'd4,
        REG_DEADZONE             = 3'd5,
        REG_FULL_SCALE           = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]   filter_weight;
        logic [THRESH_W-1:0]   stable_threshold;
        logic [COUNT_W-1:0]    stable_count_needed;
        logic [INTERVAL_W-1:0] stable_interval_ms;
        logic [INTERVAL_W-1:0] unstable_interval_ms;
        logic [THRESH_W-1:0]   deadzone;
        logic [FS_W-1:0]       full_scale;
    } cfg_t;

    typedef struct packed {
        logic                       sensor_ready;
        logic signed [SAMPLE_W-1:0] force_sample;
        logic [TIME_W-1:0]          now_ms;
    } item_t;

    typedef struct packed {
        logic               update;
        logic               below_deadzone;
        logic               stable;
        logic [FORCE_W-1:0] smoothed;
        logic [FORCE_W-1:0] peak;
    } mid_t;

    typedef struct packed {
        logic               display_update;
        logic [FORCE_W-1:0] smoothed_force;
        logic [FORCE_W-1:0] peak_force;
        logic               is_stable;
    } result_t;

endpackage

>>> rtl/fpbm_cfg.sv
module fpbm_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [fpbm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [fpbm_pkg::CFG_DATA_W-1:0]  wr_data,
    output fpbm_pkg::cfg_t                   cfg
);

    fpbm_pkg::cfg_t cfg_reg;
    fpbm_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (fpbm_pkg::cfg_reg_t'(wr_index))
                fpbm_pkg::REG_FILTER_WEIGHT:
                    cfg_next.filter_weight = wr_data[fpbm_pkg::WEIGHT_W-1:0];
                fpbm_pkg::REG_STABLE_THRESHOLD:
                    cfg_next.stable_threshold = wr_data[fpbm_pkg::THRESH_W-1:0];
                fpbm_pkg::REG_STABLE_COUNT_NEEDED:
                    cfg_next.stable_count_needed = wr_data[fpbm_pkg::COUNT_W-1:0];
                fpbm_pkg::REG_STABLE_INTERVAL_MS:
                    cfg_next.stable_interval_ms = wr_data[fpbm_pkg::INTERVAL_W-1:0];
                fpbm_pkg::REG_UNSTABLE_INTERVAL_MS:
                    cfg_next.unstable_interval_ms = wr_data[fpbm_pkg::INTERVAL_W-1:0];
                fpbm_pkg::REG_DEADZONE:
                    cfg_next.deadzone = wr_data[fpbm_pkg::THRESH_W-1:0];
                fpbm_pkg::REG_FULL_SCALE:
                    cfg_next.full_scale = wr_data[fpbm_pkg::FS_W-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_weight        <= fpbm_pkg::FILTER_WEIGHT_RST;
            cfg_reg.stable_threshold     <= fpbm_pkg::STABLE_THRESH_RST;
            cfg_reg.stable_count_needed  <= fpbm_pkg::STABLE_COUNT_RST;
            cfg_reg.stable_interval_ms   <= fpbm_pkg::STABLE_IVL_RST;
            cfg_reg.unstable_interval_ms <= fpbm_pkg::UNSTABLE_IVL_RST;
            cfg_reg.deadzone             <= fpbm_pkg::DEADZONE_RST;
            cfg_reg.full_scale           <= fpbm_pkg::FULL_SCALE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/fpbm_core.sv
module fpbm_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  fpbm_pkg::item_t item,
    input  fpbm_pkg::cfg_t  cfg,
    output fpbm_pkg::mid_t  mid
);

    localparam int FW = fpbm_pkg::FORCE_W;
    localparam int AW = fpbm_pkg::ACC_W;
    localparam int WW = fpbm_pkg::WEIGHT_W;
    localparam int CW = fpbm_pkg::COUNT_W;
    localparam int TW = fpbm_pkg::TIME_W;

    logic [FW-1:0] filter_value_reg, filter_value_next;
    logic          first_sample_reg;
    logic [FW-1:0] reference_reg, reference_next;
    logic [CW-1:0] steady_count_reg, steady_count_next;
    logic [FW-1:0] peak_reg, peak_next;
    logic [TW-1:0] last_update_reg, last_update_next;
    fpbm_pkg::mid_t mid_reg, mid_next;

    logic [FW-1:0] sample;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] w_inv;
    logic [AW-1:0] acc;
    logic [FW-1:0] smoothed;
    logic [FW-1:0] diff;
    logic          steady;
    logic [CW-1:0] count_inc;
    logic          stable;
    logic [TW-1:0] elapsed;
    logic [TW-1:0] interval;
    logic          update;

    always_comb begin
        // not ready or negative counts as zero
        if (!item.sensor_ready || item.force_sample[fpbm_pkg::SAMPLE_W-1]) begin
            sample = '0;
        end else begin
            sample = item.force_sample[FW-1:0];
        end

        w_eff = (cfg.filter_weight > WW'(fpbm_pkg::WEIGHT_ONE)) ?
                WW'(fpbm_pkg::WEIGHT_ONE) : cfg.filter_weight;
        w_inv = WW'(fpbm_pkg::WEIGHT_ONE) - w_eff;
        acc   = AW'(w_eff) * AW'(sample) + AW'(w_inv) * AW'(filter_value_reg)
              + AW'(fpbm_pkg::ROUND_HALF);
        smoothed = first_sample_reg ? sample : acc[fpbm_pkg::W_SHIFT +: FW];

        diff   = (smoothed >= reference_reg) ? (smoothed - reference_reg)
                                             : (reference_reg - smoothed);
        steady = diff < FW'(cfg.stable_threshold);
        count_inc = (steady_count_reg < CW'(fpbm_pkg::STEADY_MAX)) ?
                    (steady_count_reg + CW'(1)) : steady_count_reg;

        stable            = 1'b0;
        steady_count_next = '0;
        reference_next    = smoothed;
        if (steady) begin
            if (count_inc >= cfg.stable_count_needed) begin
                stable            = 1'b1;
                steady_count_next = cfg.stable_count_needed;
            end else begin
                steady_count_next = count_inc;
                reference_next    = reference_reg;
            end
        end

        peak_next = (smoothed > peak_reg) ? smoothed : peak_reg;

        elapsed  = item.now_ms - last_update_reg;
        interval = stable ? TW'(cfg.stable_interval_ms) : TW'(cfg.unstable_interval_ms);
        update   = elapsed >= interval;
        last_update_next = update ? item.now_ms : last_update_reg;

        filter_value_next = smoothed;

        mid_next.update         = update;
        mid_next.below_deadzone = smoothed < FW'(cfg.deadzone);
        mid_next.stable         = stable;
        mid_next.smoothed       = smoothed;
        mid_next.peak           = peak_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_value_reg <= '0;
            first_sample_reg <= 1'b1;
            reference_reg    <= '0;
            steady_count_reg <= '0;
            peak_reg         <= '0;
            last_update_reg  <= '0;
        end else if (load) begin
            filter_value_reg <= filter_value_next;
            first_sample_reg <= 1'b0;
            reference_reg    <= reference_next;
            steady_count_reg <= steady_count_next;
            peak_reg         <= peak_next;
            last_update_reg  <= last_update_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

>>> rtl/fpbm_bar.sv
module fpbm_bar (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  fpbm_pkg::mid_t                mid,
    input  logic [fpbm_pkg::FS_W-1:0]     full_scale,
    output fpbm_pkg::result_t             result,
    output logic [fpbm_pkg::LED_W-1:0]    led_count
);

    localparam int FW = fpbm_pkg::FORCE_W;
    localparam int SW = fpbm_pkg::BAR_SCALE_W;
    localparam int NW = fpbm_pkg::BAR_CNT_W;
    localparam int LW = fpbm_pkg::LED_W;
    localparam int VW = fpbm_pkg::FS_W;

    logic [VW-1:0] fs_eff;
    logic [VW-1:0] clipped;
    logic [SW-1:0] scaled;
    logic [NW-1:0] bar_count;
    logic [LW-1:0] shown_leds_reg, shown_leds_next;
    fpbm_pkg::result_t result_reg, result_next;

    always_comb begin
        fs_eff  = (full_scale == '0) ? VW'(1) : full_scale;
        clipped = (mid.peak > FW'(fs_eff)) ? fs_eff : mid.peak[VW-1:0];
        scaled  = SW'(2 * fpbm_pkg::BAR_LEDS) * SW'(clipped);

        // rounded bar: one compare per led against odd multiples of full scale
        bar_count = '0;
        for (int k = 1; k <= fpbm_pkg::BAR_LEDS; k++) begin
            if (scaled >= SW'(2 * k - 1) * SW'(fs_eff)) begin
                bar_count = bar_count + NW'(1);
            end
        end

        shown_leds_next = shown_leds_reg;
        if (mid.update) begin
            shown_leds_next = mid.below_deadzone ? '0 : LW'(bar_count);
        end

        result_next.display_update = mid.update;
        result_next.smoothed_force = mid.smoothed;
        result_next.peak_force     = mid.peak;
        result_next.is_stable      = mid.stable;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_leds_reg <= '0;
        end else if (load) begin
            shown_leds_reg <= shown_leds_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result    = result_reg;
    assign led_count = shown_leds_reg;

endmodule

>>> rtl/force_peak_bar_meter.sv
// path: an accepted beat passes the input register, the core stage and the bar stage to m_valid
// throughput: one beat per cycle unless m_ready stalls the output; each stage advances when the next is free
// the filter, stability and timing state update in the core stage, the led bar in the bar stage after it
// reset (aresetn low, synchronous): config registers return to defaults, filter restarts
// with its first-sample pass, peak, timer and bar go to zero, pipeline empties
`include "force_peak_bar_meter_macros.svh"

module force_peak_bar_meter (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fpbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpbm_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_sensor_ready,
    input  logic signed [fpbm_pkg::SAMPLE_W-1:0] s_force_sample,
    input  logic [fpbm_pkg::TIME_W-1:0]         s_now_ms,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_display_update,
    output logic [fpbm_pkg::LED_W-1:0]          m_led_count,
    output logic [fpbm_pkg::FORCE_W-1:0]        m_smoothed_force,
    output logic [fpbm_pkg::FORCE_W-1:0]        m_peak_force,
    output logic                                m_is_stable
);

    fpbm_pkg::cfg_t    cfg;
    fpbm_pkg::item_t   item_reg;
    fpbm_pkg::mid_t    mid;
    fpbm_pkg::result_t result;

    logic in_valid_reg, in_valid_next;
    logic mid_valid_reg, mid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic in_accept;
    logic out_free;
    logic adv_bar;
    logic mid_free;
    logic adv_core;

    assign cfg_ready = 1'b1;

    fpbm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    always_comb begin
        out_free  = !out_valid_reg || m_ready;
        adv_bar   = mid_valid_reg && out_free;
        mid_free  = !mid_valid_reg || adv_bar;
        adv_core  = in_valid_reg && mid_free;
        s_ready   = !in_valid_reg || adv_core;
        in_accept = s_valid && s_ready;

        in_valid_next  = in_accept ? 1'b1 : (adv_core ? 1'b0 : in_valid_reg);
        mid_valid_next = adv_core ? 1'b1 : (adv_bar ? 1'b0 : mid_valid_reg);
        out_valid_next = adv_bar ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            item_reg.sensor_ready <= s_sensor_ready;
            item_reg.force_sample <= s_force_sample;
            item_reg.now_ms       <= s_now_ms;
        end
    end

    fpbm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (adv_core),
        .item    (item_reg),
        .cfg     (cfg),
        .mid     (mid)
    );

    fpbm_bar u_bar (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (adv_bar),
        .mid        (mid),
        .full_scale (cfg.full_scale),
        .result     (result),
        .led_count  (m_led_count)
    );

    assign m_valid          = out_valid_reg;
    assign m_display_update = result.display_update;
    assign m_smoothed_force = result.smoothed_force;
    assign m_peak_force     = result.peak_force;
    assign m_is_stable      = result.is_stable;

    `FPBM_ASSERT_NOW(a_peak_covers_smoothed, m_valid, m_peak_force >= m_smoothed_force, "peak below smoothed force")
    `FPBM_ASSERT_NOW(a_lit_above_deadzone, m_valid && m_display_update && (m_led_count != '0), m_smoothed_force >= fpbm_pkg::FORCE_W'(cfg.deadzone), "leds lit below deadzone")
    `FPBM_ASSERT_NEXT(a_bar_held, !(adv_bar && mid.update), $stable(m_led_count), "bar changed without update")
    `FPBM_ASSERT_NOW(a_led_range, m_valid, int'(m_led_count) <= fpbm_pkg::BAR_LEDS, "led count out of range")

endmodule
